// File: rtl/lfp_pkg.sv
package lfp_pkg;

    // Header layout: 4 length bytes, 1 type byte, 4 request id bytes
    localparam logic [3:0]  LEN_BYTES     = 4'd4;
    localparam logic [3:0]  HDR_BYTES     = 4'd9;
    localparam logic [31:0] MIN_LEN       = 32'd5;
    localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;

    // Default depth of the result queue between parser and output stage
    localparam int LFP_QUEUE_DEPTH = 4;

    // One result item
    typedef struct packed {
        logic [7:0]  msg_type;
        logic [31:0] request_id;
        logic [7:0]  body_byte;
        logic        byte_valid;
        logic        frame_end;
        logic        length_error;
    } t_result;

endpackage

// File: rtl/lfp_front.sv
module lfp_front
    import lfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [31:0] r_max_len;
    logic [3:0]  r_hdr_cnt;
    logic [31:0] r_len;
    logic [7:0]  r_type;
    logic [31:0] r_id;
    logic [31:0] r_rem;

    logic [31:0] n_max_len;
    logic [3:0]  n_hdr_cnt;
    logic [31:0] n_len;
    logic [7:0]  n_type;
    logic [31:0] n_id;
    logic [31:0] n_rem;

    // Classify the accepted byte by header position and build its result
    always_comb begin
        n_max_len   = i_cfg_we ? i_cfg_wdata : r_max_len;
        n_hdr_cnt   = r_hdr_cnt;
        n_len       = r_len;
        n_type      = r_type;
        n_id        = r_id;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (r_hdr_cnt < LEN_BYTES) begin
                n_len     = {r_len[23:0], i_rx_byte};
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (r_hdr_cnt == LEN_BYTES - 4'd1 &&
                    (n_len > r_max_len || n_len < MIN_LEN)) begin
                    n_hdr_cnt          = '0;
                    n_len              = '0;
                    o_res_valid        = 1'b1;
                    o_res.length_error = 1'b1;
                end
            end else if (r_hdr_cnt == LEN_BYTES) begin
                n_type    = i_rx_byte;
                n_id      = '0;
                n_hdr_cnt = r_hdr_cnt + 4'd1;
            end else if (r_hdr_cnt < HDR_BYTES) begin
                n_id      = {r_id[23:0], i_rx_byte};
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (r_hdr_cnt == HDR_BYTES - 4'd1) begin
                    n_rem = r_len - MIN_LEN;
                    // Empty body: one marker result closes the frame
                    if (r_len == MIN_LEN) begin
                        n_hdr_cnt        = '0;
                        n_len            = '0;
                        o_res_valid      = 1'b1;
                        o_res.msg_type   = r_type;
                        o_res.request_id = n_id;
                        o_res.frame_end  = 1'b1;
                    end
                end
            end else begin
                // Body byte: tag it and count down
                o_res_valid      = 1'b1;
                o_res.msg_type   = r_type;
                o_res.request_id = r_id;
                o_res.body_byte  = i_rx_byte;
                o_res.byte_valid = 1'b1;
                n_rem            = (r_rem != '0) ? r_rem - 32'd1 : '0;
                if (r_rem <= 32'd1) begin
                    n_hdr_cnt       = '0;
                    n_len           = '0;
                    o_res.frame_end = 1'b1;
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
            r_hdr_cnt <= '0;
        end else begin
            r_max_len <= n_max_len;
            r_hdr_cnt <= n_hdr_cnt;
        end
        r_len  <= n_len;
        r_type <= n_type;
        r_id   <= n_id;
        r_rem  <= n_rem;
    end

    // A rejected length always sends the parser back to the length field
    a_err_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.length_error) |=> (r_hdr_cnt == '0))
        else $error("parser did not restart after length error");

endmodule

// File: rtl/lfp_queue.sv
module lfp_queue
    import lfp_pkg::*;
#(
    parameter int DEPTH = LFP_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_wdata,
    output logic    o_full,
    input  logic    i_rd,
    output t_result o_rdata,
    output logic    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the last entry
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_rd && !i_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming result
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("write into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_rd)
        else $error("read from empty result queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not follow a write");

endmodule

// File: rtl/lfp_back.sv
module lfp_back
    import lfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_result i_q_data,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Refill the output register when it is free or being taken
    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
        if (o_q_rd) begin
            r_res <= i_q_data;
        end
    end

endmodule

// File: rtl/length_prefixed_frame_parser.sv
// Length-prefixed frame parser.
// Input channel: one received byte on i_rx_byte per transfer, taken at a
// clock edge with push high and full low. Frames are a 4-byte big-endian
// length, a type byte, a 4-byte big-endian request id, then the body.
// Result channel: while empty is low the oldest result sits on the o_ ports;
// pop high at a clock edge takes it. Each body byte gives one result tagged
// with type and id; the last is marked o_frame_end. An empty body gives one
// marker result, a length above the maximum or below 5 gives an error result.
// Throughput is one byte per cycle while full is low; a result reaches the o_ ports
// through the queue and the output register after the transfer of its byte (the
// queue takes it at that edge, then the output register loads it), later if older results are still waiting.
// Configuration: i_cfg_we writes i_cfg_wdata as the maximum length; write it
// only while the block is idle.
// Reset: parser waits for a length field, queue and output register empty,
// maximum length 4194304.
// Stall: results build up in the queue (QUEUE_DEPTH entries) plus the output
// register; full rises once the queue is full and clears as pop drains it.
module length_prefixed_frame_parser
    import lfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = LFP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_request_id,
    output logic [7:0]  o_body_byte,
    output logic        o_byte_valid,
    output logic        o_frame_end,
    output logic        o_length_error
);

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    q_empty;
    logic    q_rd;
    t_result q_data;
    t_result out_res;

    assign accept = push && !full;

    lfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_empty (q_empty)
    );

    lfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (out_res)
    );

    // Drive result fields
    assign o_msg_type     = out_res.msg_type;
    assign o_request_id   = out_res.request_id;
    assign o_body_byte    = out_res.body_byte;
    assign o_byte_valid   = out_res.byte_valid;
    assign o_frame_end    = out_res.frame_end;
    assign o_length_error = out_res.length_error;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import lfp_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_msg_type;
    logic [31:0] o_request_id;
    logic [7:0]  o_body_byte;
    logic        o_byte_valid;
    logic        o_frame_end;
    logic        o_length_error;

    // Deframer mirror: configured limit and parse state
    logic [31:0] max_len_cfg = MAX_LEN_RESET;
    logic [3:0]  hdr_cnt = '0;
    logic [31:0] len_acc = '0;
    logic [7:0]  cur_type = '0;
    logic [31:0] cur_id = '0;
    logic [31:0] body_left = '0;

    logic [7:0]  byte_backlog[$];
    t_result     expected_results[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic receiver_held = 1'b0;

    int bytes_sent = 0;
    int results_checked = 0;
    int frames_seen = 0;
    int rejects_seen = 0;
    int full_cycles = 0;
    int mismatch_count = 0;
    int limits_used = 1;

    length_prefixed_frame_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .empty          (empty),
        .pop            (pop),
        .o_msg_type     (o_msg_type),
        .o_request_id   (o_request_id),
        .o_body_byte    (o_body_byte),
        .o_byte_valid   (o_byte_valid),
        .o_frame_end    (o_frame_end),
        .o_length_error (o_length_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the deframer mirror by one stream byte, queue any result it gives
    function void parse_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (hdr_cnt < LEN_BYTES) begin
            len_acc = {len_acc[23:0], b};
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt == LEN_BYTES && (len_acc > max_len_cfg || len_acc < MIN_LEN)) begin
                hdr_cnt = '0;
                len_acc = '0;
                r.length_error = 1'b1;
                expected_results.push_back(r);
            end
        end else if (hdr_cnt == LEN_BYTES) begin
            cur_type = b;
            cur_id = '0;
            hdr_cnt = LEN_BYTES + 4'd1;
        end else if (hdr_cnt < HDR_BYTES) begin
            cur_id = {cur_id[23:0], b};
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt == HDR_BYTES) begin
                body_left = len_acc - MIN_LEN;
                // empty body: one marker with no data byte
                if (body_left == 0) begin
                    hdr_cnt = '0;
                    len_acc = '0;
                    r.msg_type = cur_type;
                    r.request_id = cur_id;
                    r.frame_end = 1'b1;
                    expected_results.push_back(r);
                end
            end
        end else begin
            if (body_left != 0) body_left = body_left - 32'd1;
            r.msg_type = cur_type;
            r.request_id = cur_id;
            r.body_byte = b;
            r.byte_valid = 1'b1;
            if (body_left == 0) begin
                hdr_cnt = '0;
                len_acc = '0;
                r.frame_end = 1'b1;
            end
            expected_results.push_back(r);
        end
    endfunction

    // Input side: predict on each transfer, hold while full, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_byte(i_rx_byte);
                byte_backlog.delete(0);
                bytes_sent++;
            end
            if (!(push && full)) begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push <= 1'b1;
                    i_rx_byte <= byte_backlog[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: check each transfer against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (full) full_cycles++;
            if (pop && !empty) begin
                got = '{o_msg_type, o_request_id, o_body_byte,
                        o_byte_valid, o_frame_end, o_length_error};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected result: type %02h id %08h byte %02h v%b e%b err%b",
                                 got.msg_type, got.request_id, got.body_byte,
                                 got.byte_valid, got.frame_end, got.length_error);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.msg_type !== want.msg_type || got.request_id !== want.request_id ||
                        got.body_byte !== want.body_byte || got.byte_valid !== want.byte_valid ||
                        got.frame_end !== want.frame_end ||
                        got.length_error !== want.length_error) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("Result %0d wrong at %0t", results_checked, $realtime);
                            $display("  expected type %02h id %08h byte %02h v%b e%b err%b",
                                     want.msg_type, want.request_id, want.body_byte,
                                     want.byte_valid, want.frame_end, want.length_error);
                            $display("  actual   type %02h id %08h byte %02h v%b e%b err%b",
                                     got.msg_type, got.request_id, got.body_byte,
                                     got.byte_valid, got.frame_end, got.length_error);
                        end
                    end
                    if (want.length_error) rejects_seen++;
                    else if (want.frame_end) frames_seen++;
                end
            end
            pop <= !receiver_held && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the result queue fills and push stalls
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        receiver_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        receiver_held <= 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("Timeout: results still outstanding");
        $display("Mismatches found");
        $finish;
    end

    task automatic put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) byte_backlog.push_back(w[8*k +: 8]);
    endtask

    // Queue one frame; a rejected length carries no header or body after it
    task automatic add_frame(input logic [31:0] len, input logic [7:0] typ,
                             input logic [31:0] id);
        put_word(len);
        if (len >= MIN_LEN && len <= max_len_cfg) begin
            byte_backlog.push_back(typ);
            put_word(id);
            repeat (len - MIN_LEN) byte_backlog.push_back(8'($urandom_range(255)));
        end
    endtask

    // Mostly good frames, some bad lengths, stray bytes only where the limit is small
    task automatic gen_traffic(input int n_bytes, input bit with_noise);
        int          pick;
        int          body_n;
        logic [31:0] span;
        logic [31:0] bad_len;
        while (byte_backlog.size() < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                body_n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
                add_frame(body_n + MIN_LEN, 8'($urandom_range(255)), $urandom);
            end else if (pick < 92 || !with_noise) begin
                span = 32'hFFFF_FFFF - max_len_cfg;
                if (span == 0 || $urandom_range(1) == 0) bad_len = $urandom_range(4);
                else bad_len = max_len_cfg + 32'd1 + ($urandom % span);
                add_frame(bad_len, 8'h00, 32'h0);
            end else begin
                repeat ($urandom_range(1, 6)) byte_backlog.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_backlog.size() != 0 || push || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Drain, then pad with zeros until the parser sits at a length boundary
    task automatic finish_phase();
        int fill_n;
        wait_drained();
        while (hdr_cnt != 0) begin
            if (hdr_cnt < LEN_BYTES) fill_n = int'(LEN_BYTES - hdr_cnt);
            else if (hdr_cnt < HDR_BYTES) fill_n = HDR_BYTES - hdr_cnt + len_acc - MIN_LEN;
            else fill_n = body_left;
            repeat (fill_n) byte_backlog.push_back(8'h00);
            wait_drained();
        end
    endtask

    task automatic write_max_len(input logic [31:0] limit);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_len_cfg = limit;
        limits_used++;
    endtask

    task automatic run_phase(input logic [31:0] limit, input int idle_pct,
                             input int stall_pct, input int n_bytes, input bit with_hold);
        write_max_len(limit);
        @(negedge i_clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_hold) hold_request = 1'b1;
        // length at the limit and just above it
        if (limit >= MIN_LEN && limit <= 32'd1000)
            add_frame(limit, 8'($urandom_range(255)), $urandom);
        if (limit != 32'hFFFF_FFFF) add_frame(limit + 32'd1, 8'h00, 32'h0);
        gen_traffic(n_bytes, limit < 32'h1_0000);
        finish_phase();
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty body with all-ones type and request id
        add_frame(MIN_LEN, 8'hFF, 32'hFFFF_FFFF);
        // Two-byte body with all-zero type and request id
        put_word(32'd7);
        byte_backlog.push_back(8'h00);
        put_word(32'h0);
        byte_backlog.push_back(8'h00);
        byte_backlog.push_back(8'hFF);
        // Too short, then one above the reset limit
        add_frame(32'd4, 8'h00, 32'h0);
        add_frame(MAX_LEN_RESET + 32'd1, 8'h00, 32'h0);
        finish_phase();

        run_phase(32'd64,          0,  0,  300, 1'b1);
        run_phase(32'hFFFF_FFFF,   76, 0,  300, 1'b0);
        run_phase(MIN_LEN,         0,  76, 200, 1'b0);
        run_phase(32'd0,           35, 35, 150, 1'b0);
        run_phase(32'd4,           0,  0,  100, 1'b0);
        run_phase(32'd1000,        35, 35, 350, 1'b0);
        run_phase(32'hFFFF_FFFE,   0,  76, 300, 1'b0);
        run_phase(MAX_LEN_RESET,   76, 76, 100, 1'b0);

        mismatch_count += expected_results.size();
        $display("Checked %0d results from %0d stream bytes under %0d length limits",
                 results_checked, bytes_sent, limits_used);
        $display("%0d frames completed, %0d lengths rejected, input stalled %0d cycles",
                 frames_seen, rejects_seen, full_cycles);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lfp_pkg.sv
rtl/lfp_front.sv
rtl/lfp_queue.sv
rtl/lfp_back.sv
rtl/length_prefixed_frame_parser.sv
bench/tb.sv
